// ===== sv/nckc_pkg.sv =====
// ----------------------------------------------------------------------------
// nckc_pkg
// Shared types, constants and arithmetic helpers for the normalized color
// key classifier.
// ----------------------------------------------------------------------------
package nckc_pkg;

  // Pixel channel and result widths
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned NUM_W   = 2 * CHAN_W;
  localparam int unsigned SQ_W    = 2 * CHAN_W;
  localparam int unsigned DIST_W  = 18;
  localparam int unsigned NUM_CH  = 3;

  // Quotient bits resolved per pipeline stage, and the number of such stages
  localparam int unsigned DIV_BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES         = CHAN_W / DIV_BITS_PER_STAGE;

  // Configuration port
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam logic [DIST_W-1:0] LIMIT_RESET = DIST_W'(25);

  // Register indexes
  typedef enum logic [1:0] {
    REG_TARGET_RED   = 2'd0,
    REG_TARGET_GREEN = 2'd1,
    REG_TARGET_BLUE  = 2'd2,
    REG_DIST_LIMIT   = 2'd3
  } reg_idx_t;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [NUM_W-1:0]  div_word_t;

  // One restoring division step. The word holds {remainder, unused numerator
  // bits}; the quotient bit shifts in at the bottom.
  function automatic div_word_t div_step(input div_word_t w, input chan_t d);
    logic [CHAN_W:0] top;
    logic [CHAN_W:0] diff;
    top  = w[NUM_W-1:CHAN_W-1];
    diff = top - {1'b0, d};
    if (top >= {1'b0, d}) begin
      div_step = {diff[CHAN_W-1:0], w[CHAN_W-2:0], 1'b1};
    end else begin
      div_step = {top[CHAN_W-1:0], w[CHAN_W-2:0], 1'b0};
    end
  endfunction

  // Scale a channel by full scale: c*255 = (c << 8) - c
  function automatic div_word_t scale_full(input chan_t c);
    scale_full = {c, CHAN_W'(0)} - {CHAN_W'(0), c};
  endfunction

endpackage

// ===== sv/normalized_color_key_classifier_core.sv =====
// ----------------------------------------------------------------------------
// normalized_color_key_classifier_core
// Throughput: one pixel per cycle while the output stall does not hold the
// pipeline; the four-stage restoring divider (two quotient bits per stage)
// sets the pipeline depth.
// Reset: synchronous active-low rst_n clears all valid bits; targets reset
// to 0 and the distance limit to 25.
// ----------------------------------------------------------------------------
module normalized_color_key_classifier_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // pixel input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [nckc_pkg::CHAN_W-1:0]    in_red,
  input  logic [nckc_pkg::CHAN_W-1:0]    in_green,
  input  logic [nckc_pkg::CHAN_W-1:0]    in_blue,
  // result output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_selected,
  output logic [nckc_pkg::CHAN_W-1:0]    out_norm_red,
  output logic [nckc_pkg::CHAN_W-1:0]    out_norm_green,
  output logic [nckc_pkg::CHAN_W-1:0]    out_norm_blue,
  output logic [nckc_pkg::DIST_W-1:0]    out_distance_sq,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nckc_pkg::ADDR_W-1:0]    paddr,
  input  logic [nckc_pkg::DATA_W-1:0]    pwdata,
  output logic [nckc_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam int unsigned NS = nckc_pkg::DIV_STAGES;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [nckc_pkg::CHAN_W-1:0] tgt_r [nckc_pkg::NUM_CH];
  logic [nckc_pkg::DIST_W-1:0] limit_r;
  nckc_pkg::reg_idx_t          reg_sel;
  logic                        cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = nckc_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;

  // Write selected register on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r[0] <= '0;
      tgt_r[1] <= '0;
      tgt_r[2] <= '0;
      limit_r  <= nckc_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        nckc_pkg::REG_TARGET_RED:   tgt_r[0] <= pwdata[nckc_pkg::CHAN_W-1:0];
        nckc_pkg::REG_TARGET_GREEN: tgt_r[1] <= pwdata[nckc_pkg::CHAN_W-1:0];
        nckc_pkg::REG_TARGET_BLUE:  tgt_r[2] <= pwdata[nckc_pkg::CHAN_W-1:0];
        nckc_pkg::REG_DIST_LIMIT:   limit_r  <= pwdata[nckc_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back selected register
  always_comb begin
    case (reg_sel)
      nckc_pkg::REG_TARGET_RED:
        prdata = {(nckc_pkg::DATA_W - nckc_pkg::CHAN_W)'(0), tgt_r[0]};
      nckc_pkg::REG_TARGET_GREEN:
        prdata = {(nckc_pkg::DATA_W - nckc_pkg::CHAN_W)'(0), tgt_r[1]};
      nckc_pkg::REG_TARGET_BLUE:
        prdata = {(nckc_pkg::DATA_W - nckc_pkg::CHAN_W)'(0), tgt_r[2]};
      nckc_pkg::REG_DIST_LIMIT:
        prdata = {(nckc_pkg::DATA_W - nckc_pkg::DIST_W)'(0), limit_r};
      default:
        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage advances together unless the output
  // register holds a result that is not taken.
  // --------------------------------------------------------------------------
  logic out_valid_r;
  logic advance;

  assign advance  = ~out_valid_r | ~out_stall;
  assign in_stall = ~advance;

  // --------------------------------------------------------------------------
  // Stage 0: find the largest channel and form c*255 per channel
  // --------------------------------------------------------------------------
  logic [nckc_pkg::CHAN_W-1:0] in_ch [nckc_pkg::NUM_CH];
  logic [nckc_pkg::CHAN_W-1:0] cmax_nxt;
  logic [nckc_pkg::CHAN_W-1:0] rg_max;

  assign in_ch[0] = in_red;
  assign in_ch[1] = in_green;
  assign in_ch[2] = in_blue;
  assign rg_max   = (in_green > in_red) ? in_green : in_red;
  assign cmax_nxt = (in_blue > rg_max) ? in_blue : rg_max;

  // Divider pipeline registers: stage 0 holds the numerator, stage k holds
  // the word after 2*k division steps.
  logic                        div_v_r    [NS+1];
  logic [nckc_pkg::CHAN_W-1:0] div_d_r    [NS+1];
  logic                        div_zero_r [NS+1];
  nckc_pkg::div_word_t         div_w_r    [NS+1][nckc_pkg::NUM_CH];
  nckc_pkg::div_word_t         div_w_nxt  [NS][nckc_pkg::NUM_CH];

  // --------------------------------------------------------------------------
  // Stages 1..NS: restoring division, two quotient bits per stage
  // --------------------------------------------------------------------------
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      for (int c = 0; c < nckc_pkg::NUM_CH; c++) begin
        div_w_nxt[s][c] = div_w_r[s][c];
        for (int k = 0; k < nckc_pkg::DIV_BITS_PER_STAGE; k++) begin
          div_w_nxt[s][c] = nckc_pkg::div_step(div_w_nxt[s][c], div_d_r[s]);
        end
      end
    end
  end

  // Load stage 0 and advance divider valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NS; s++) begin
        div_v_r[s] <= 1'b0;
      end
    end else if (advance) begin
      div_v_r[0] <= in_valid;
      for (int s = 1; s <= NS; s++) begin
        div_v_r[s] <= div_v_r[s-1];
      end
    end
  end

  // Load stage 0 and advance divider data
  always_ff @(posedge clk) begin
    if (advance) begin
      div_d_r[0]    <= cmax_nxt;
      div_zero_r[0] <= (cmax_nxt == '0);
      for (int c = 0; c < nckc_pkg::NUM_CH; c++) begin
        div_w_r[0][c] <= nckc_pkg::scale_full(in_ch[c]);
      end
      for (int s = 1; s <= NS; s++) begin
        div_d_r[s]    <= div_d_r[s-1];
        div_zero_r[s] <= div_zero_r[s-1];
        for (int c = 0; c < nckc_pkg::NUM_CH; c++) begin
          div_w_r[s][c] <= div_w_nxt[s-1][c];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Square stage: take quotient (zero for a black pixel), square the
  // difference to the target per channel
  // --------------------------------------------------------------------------
  logic [nckc_pkg::CHAN_W-1:0] norm_nxt [nckc_pkg::NUM_CH];
  logic [nckc_pkg::CHAN_W-1:0] diff_nxt [nckc_pkg::NUM_CH];
  logic [nckc_pkg::SQ_W-1:0]   sq_nxt   [nckc_pkg::NUM_CH];
  logic [nckc_pkg::CHAN_W-1:0] norm_r   [nckc_pkg::NUM_CH];
  logic [nckc_pkg::SQ_W-1:0]   sq_r     [nckc_pkg::NUM_CH];
  logic                        sq_v_r;

  always_comb begin
    for (int c = 0; c < nckc_pkg::NUM_CH; c++) begin
      norm_nxt[c] = div_zero_r[NS] ? '0 : div_w_r[NS][c][nckc_pkg::CHAN_W-1:0];
      diff_nxt[c] = (norm_nxt[c] >= tgt_r[c]) ? (norm_nxt[c] - tgt_r[c])
                                               : (tgt_r[c] - norm_nxt[c]);
      sq_nxt[c]   = nckc_pkg::SQ_W'(diff_nxt[c]) * nckc_pkg::SQ_W'(diff_nxt[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else if (advance) begin
      sq_v_r <= div_v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int c = 0; c < nckc_pkg::NUM_CH; c++) begin
        norm_r[c] <= norm_nxt[c];
        sq_r[c]   <= sq_nxt[c];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: sum the squares and compare against the limit
  // --------------------------------------------------------------------------
  logic [nckc_pkg::DIST_W-1:0] dist_nxt;
  logic [nckc_pkg::DIST_W-1:0] dist_r;
  logic                        sel_r;
  logic [nckc_pkg::CHAN_W-1:0] out_norm_r [nckc_pkg::NUM_CH];

  assign dist_nxt = nckc_pkg::DIST_W'(sq_r[0]) + nckc_pkg::DIST_W'(sq_r[1])
                  + nckc_pkg::DIST_W'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dist_r <= dist_nxt;
      sel_r  <= (dist_nxt < limit_r);
      for (int c = 0; c < nckc_pkg::NUM_CH; c++) begin
        out_norm_r[c] <= norm_r[c];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_selected    = sel_r;
  assign out_norm_red    = out_norm_r[0];
  assign out_norm_green  = out_norm_r[1];
  assign out_norm_blue   = out_norm_r[2];
  assign out_distance_sq = dist_r;

endmodule
